// ----- design/differential_drive_goto_controller_unit_assert.svh -----
// assertion macros for the go-to-point controller
`ifndef DIFFERENTIAL_DRIVE_GOTO_CONTROLLER_UNIT_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_GOTO_CONTROLLER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DDGC_ASSERT_IMPLY(name, a, c) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("ddgc implication check failed");
`define DDGC_ASSERT_NEXT(name, a, c) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("ddgc next-cycle check failed");
`else
`define DDGC_ASSERT_IMPLY(name, a, c)
`define DDGC_ASSERT_NEXT(name, a, c)
`endif
`endif

// ----- design/ddgc_pkg.sv -----
// shared types, constants and tables of the go-to-point controller
package ddgc_pkg;

    localparam int POS_WIDTH_DEF   = 24;
    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int CORDIC_STEPS    = 24;
    localparam int CORDIC_W        = 64;
    localparam int FRAC_STEPS      = 16;
    localparam int SPEED_W         = 17;
    localparam int Q16_W           = 17;
    localparam logic [Q16_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [32:0] HALF_RAD_T32 = 33'd341782638;
    localparam logic [31:0] ACC_QUARTER  = 32'h4000_0000;
    localparam logic [31:0] ACC_3QUARTER = 32'hC000_0000;
    localparam int K_TURN = 80;
    localparam int K_FWD  = 120;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SET_X = 2'd1;
    localparam logic [1:0] OP_SET_Y = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ0,
        S_SQ1,
        S_ROT,
        S_ANG,
        S_DIVA,
        S_RPT,
        S_DIVD,
        S_MPT,
        S_FIN
    } state_t;

    typedef struct packed {
        logic take;
        logic load;
        logic sq_init;
        logic sq_add;
        logic rot_step;
        logic ang;
        logic div_step;
        logic rp_take;
        logic mp_take;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_tick;
        logic rot_last;
        logic div_last;
        logic out_free;
    } sts_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_step(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/ddgc_if.sv -----
// request channels of the go-to-point controller
interface ddgc_in_if #(
    parameter int POS_WIDTH   = ddgc_pkg::POS_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ddgc_pkg::ANGLE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    op;
    logic signed [POS_WIDTH-1:0]   coord_x;
    logic signed [POS_WIDTH-1:0]   coord_y;
    logic [ANGLE_WIDTH-1:0]        heading;

    modport source (output valid, op, coord_x, coord_y, heading, input ready);
    modport sink (input valid, op, coord_x, coord_y, heading, output ready);
endinterface

interface ddgc_out_if;
    import ddgc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      moving;
    logic                      drive_on;
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
    logic                      left_reverse;
    logic                      right_reverse;
    logic                      arrived;

    modport source (output valid, moving, drive_on, left_speed, right_speed,
                    left_reverse, right_reverse, arrived, input ready);
    modport sink (input valid, moving, drive_on, left_speed, right_speed,
                  left_reverse, right_reverse, arrived, output ready);
endinterface

// ----- design/ddgc_ctrl.sv -----
// sequencer of the go-to-point controller
module ddgc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  ddgc_pkg::sts_t sts,
    output ddgc_pkg::cmd_t cmd
);
    import ddgc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sts.in_valid)
                begin
                    state_next = sts.in_tick ? S_SQ0 : S_FIN;
                end
            end
            S_SQ0: state_next = S_SQ1;
            S_SQ1: state_next = S_ROT;
            S_ROT:
            begin
                if (sts.rot_last)
                begin
                    state_next = S_ANG;
                end
            end
            S_ANG: state_next = S_DIVA;
            S_DIVA:
            begin
                if (sts.div_last)
                begin
                    state_next = S_RPT;
                end
            end
            S_RPT: state_next = S_DIVD;
            S_DIVD:
            begin
                if (sts.div_last)
                begin
                    state_next = S_MPT;
                end
            end
            S_MPT: state_next = S_FIN;
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.take = 1'b1;
                cmd.load = sts.in_valid;
            end
            S_SQ0:  cmd.sq_init = 1'b1;
            S_SQ1:  cmd.sq_add = 1'b1;
            S_ROT:  cmd.rot_step = 1'b1;
            S_ANG:  cmd.ang = 1'b1;
            S_DIVA: cmd.div_step = 1'b1;
            S_RPT:  cmd.rp_take = 1'b1;
            S_DIVD: cmd.div_step = 1'b1;
            S_MPT:  cmd.mp_take = 1'b1;
            S_FIN:  cmd.commit = sts.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

// ----- design/ddgc_datapath.sv -----
// arithmetic, controller state and result register of the go-to-point controller
module ddgc_datapath #(
    parameter int POS_WIDTH   = ddgc_pkg::POS_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ddgc_pkg::ANGLE_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ddgc_pkg::cmd_t cmd,
    output ddgc_pkg::sts_t sts,
    ddgc_in_if.sink        in_ch,
    ddgc_out_if.source     out_ch
);
    import ddgc_pkg::*;

    localparam int DX_W  = POS_WIDTH + 1;
    localparam int SQ_W  = 2 * POS_WIDTH + 2;
    localparam int R_W   = POS_WIDTH + 1;
    localparam int REM_W = POS_WIDTH + 4;
    localparam int ROT_STEPS = (R_W > CORDIC_STEPS) ? R_W : CORDIC_STEPS;
    localparam int CNT_W = $clog2(ROT_STEPS);
    localparam int D_W   = ((R_W > ANGLE_WIDTH) ? R_W : ANGLE_WIDTH) + 1;
    localparam int SCALE = 60 - POS_WIDTH;
    localparam int AW    = ANGLE_WIDTH;
    localparam logic [31:0] ROUND_HALF = 32'(1) << (31 - AW);
    localparam logic signed [AW-1:0] QUARTER = AW'(1) << (AW - 2);

    logic [1:0]                  op_reg;
    logic signed [POS_WIDTH-1:0] goal_x_reg;
    logic signed [POS_WIDTH-1:0] goal_y_reg;
    logic                        move_mode_reg;
    logic [R_W-1:0]              start_dist_reg;
    logic [AW-1:0]               start_angle_reg;
    logic signed [DX_W-1:0]      dx_reg;
    logic signed [DX_W-1:0]      dy_reg;
    logic [AW-1:0]               heading_reg;
    logic                        zero_reg;
    logic [SQ_W-1:0]             sum_reg;
    logic signed [CORDIC_W-1:0]  cx_reg;
    logic signed [CORDIC_W-1:0]  cy_reg;
    logic [31:0]                 acc_reg;
    logic [REM_W-1:0]            rem_reg;
    logic [R_W-1:0]              root_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic signed [AW-1:0]        rel_reg;
    logic [AW-1:0]               arel_reg;
    logic [AW-1:0]               ainit_reg;
    logic [R_W-1:0]              dist_reg;
    logic [D_W-1:0]              drem_reg;
    logic [D_W-1:0]              dden_reg;
    logic [FRAC_STEPS-1:0]       quo_reg;
    logic [Q16_W-1:0]            rp_reg;
    logic [Q16_W-1:0]            mp_reg;

    logic                        out_valid_reg;
    logic                        o_moving_reg;
    logic                        o_drive_reg;
    logic signed [SPEED_W-1:0]   o_ls_reg;
    logic signed [SPEED_W-1:0]   o_rs_reg;
    logic                        o_lrev_reg;
    logic                        o_rrev_reg;
    logic                        o_arrived_reg;

    // magnitudes of the offsets and the shared squarer
    logic [DX_W-1:0] mag_dx;
    logic [DX_W-1:0] mag_dy;
    logic [DX_W-1:0] sq_op;
    logic [SQ_W-1:0] sq_prod;

    assign mag_dx  = dx_reg[DX_W-1] ? DX_W'(-dx_reg) : DX_W'(dx_reg);
    assign mag_dy  = dy_reg[DX_W-1] ? DX_W'(-dy_reg) : DX_W'(dy_reg);
    assign sq_op   = cmd.sq_add ? mag_dy : mag_dx;
    assign sq_prod = SQ_W'(sq_op) * SQ_W'(sq_op);

    // cordic pre-rotation into the right half plane
    logic signed [CORDIC_W-1:0] dxs;
    logic signed [CORDIC_W-1:0] dys;
    logic signed [CORDIC_W-1:0] cx_init;
    logic signed [CORDIC_W-1:0] cy_init;
    logic [31:0]                acc_init;

    always_comb
    begin
        dxs = CORDIC_W'(dx_reg) <<< SCALE;
        dys = CORDIC_W'(dy_reg) <<< SCALE;
        cx_init = dxs;
        cy_init = dys;
        acc_init = '0;
        if (dxs < 0)
        begin
            if (dys >= 0)
            begin
                cx_init = dys;
                cy_init = -dxs;
                acc_init = ACC_QUARTER;
            end
            else
            begin
                cx_init = -dys;
                cy_init = dxs;
                acc_init = ACC_3QUARTER;
            end
        end
    end

    // per step: one cordic rotation while fewer than CORDIC_STEPS are done, one root digit while fewer than R_W
    logic [4:0]                 rot_idx;
    logic signed [CORDIC_W-1:0] xsh;
    logic signed [CORDIC_W-1:0] ysh;
    logic [REM_W-1:0]           rem_sh;
    logic [REM_W-1:0]           root_trial;

    assign rot_idx    = cnt_reg[4:0];
    assign xsh        = cx_reg >>> rot_idx;
    assign ysh        = cy_reg >>> rot_idx;
    assign rem_sh     = {rem_reg[REM_W-3:0], sum_reg[SQ_W-1:SQ_W-2]};
    assign root_trial = REM_W'({root_reg, 2'b01});

    // bearing, relative angle and start captures
    logic [31:0]          bear_sum;
    logic [AW-1:0]        bear;
    logic [AW-1:0]        relu;
    logic signed [AW-1:0] rel_s;
    logic [AW-1:0]        sa_next;
    logic signed [AW-1:0] sa_s;
    logic [R_W-1:0]       sd_next;

    always_comb
    begin
        bear_sum = acc_reg + ROUND_HALF;
        bear     = zero_reg ? '0 : bear_sum[31:32-AW];
        relu     = bear - heading_reg;
        rel_s    = $signed(relu);
        sa_next  = (start_angle_reg == '0) ? relu : start_angle_reg;
        sa_s     = $signed(sa_next);
        sd_next  = (start_dist_reg == '0) ? root_reg : start_dist_reg;
    end

    // restoring divider step
    logic [D_W-1:0] drem_sh;
    assign drem_sh = {drem_reg[D_W-2:0], 1'b0};

    // speed setpoints and state update on commit
    logic [Q16_W-1:0]          rp_inv;
    logic [Q16_W-1:0]          mp_inv_n;
    logic [24:0]               turn_prod;
    logic [24:0]               fwd_prod;
    logic [24:0]               spin_prod;
    logic signed [SPEED_W:0]   ls_c;
    logic signed [SPEED_W:0]   rs_c;
    logic                      lrev_c;
    logic                      rrev_c;
    logic                      drive_c;
    logic                      move_next;
    logic signed [POS_WIDTH-1:0] gx_next;
    logic signed [POS_WIDTH-1:0] gy_next;
    logic                      clear_start;
    logic                      steer_c;
    logic                      spin_c;
    logic                      stop_c;
    logic [32:0]               arel_t32;

    always_comb
    begin
        rp_inv    = ONE_Q16 - rp_reg;
        mp_inv_n  = mp_reg;
        turn_prod = 25'(K_TURN) * 25'(rp_inv);
        fwd_prod  = 25'(K_FWD) * 25'(mp_inv_n);
        spin_prod = 25'(K_FWD) * 25'(rp_inv);
        arel_t32  = 33'(arel_reg) << (32 - AW);
        steer_c   = (20'(mp_reg) * 20'd5 < 20'(ONE_Q16) * 20'd4)
                    && (21'(rp_reg) * 21'd10 > 21'(ONE_Q16) * 21'd7);
        spin_c    = (arel_t32 > HALF_RAD_T32) && (18'(mp_reg) * 18'd2 < 18'(ONE_Q16));
        stop_c    = ((rel_reg > QUARTER) || (rel_reg < -QUARTER))
                    && (18'(mp_reg) * 18'd2 > 18'(ONE_Q16));
        ls_c        = '0;
        rs_c        = '0;
        lrev_c      = 1'b0;
        rrev_c      = 1'b0;
        drive_c     = 1'b0;
        move_next   = move_mode_reg;
        gx_next     = goal_x_reg;
        gy_next     = goal_y_reg;
        clear_start = 1'b0;
        if (op_reg == OP_TICK)
        begin
            if (!move_mode_reg)
            begin
                clear_start = 1'b1;
                move_next = (goal_x_reg != '0) || (goal_y_reg != '0);
            end
            else
            begin
                drive_c = 1'b1;
                if (steer_c)
                begin
                    if (rel_reg < 0)
                    begin
                        ls_c = (SPEED_W+1)'(turn_prod[24:8]);
                        rs_c = -(SPEED_W+1)'(turn_prod[24:8]);
                    end
                    else
                    begin
                        ls_c = -(SPEED_W+1)'(turn_prod[24:8]);
                        rs_c = (SPEED_W+1)'(turn_prod[24:8]);
                    end
                end
                ls_c = ls_c + (SPEED_W+1)'(fwd_prod[24:8]);
                rs_c = rs_c + (SPEED_W+1)'(fwd_prod[24:8]);
                if (spin_c)
                begin
                    ls_c = (SPEED_W+1)'(K_TURN * 256) + (SPEED_W+1)'(spin_prod[24:8]);
                    rs_c = ls_c;
                    lrev_c = rel_reg > 0;
                    rrev_c = !(rel_reg > 0);
                end
                if (stop_c)
                begin
                    move_next = 1'b0;
                    gx_next = '0;
                    gy_next = '0;
                    drive_c = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg      <= '0;
            goal_y_reg      <= '0;
            move_mode_reg   <= 1'b0;
            start_dist_reg  <= '0;
            start_angle_reg <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                case (in_ch.op)
                    OP_SET_X: goal_x_reg <= in_ch.coord_x;
                    OP_SET_Y: goal_y_reg <= in_ch.coord_y;
                    default:  goal_x_reg <= goal_x_reg;
                endcase
            end
            if (cmd.sq_add || cmd.ang || cmd.rp_take)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.rot_step || cmd.div_step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.ang)
            begin
                start_angle_reg <= sa_next;
                start_dist_reg  <= sd_next;
            end
            if (cmd.commit)
            begin
                move_mode_reg <= move_next;
                goal_x_reg    <= gx_next;
                goal_y_reg    <= gy_next;
                if (clear_start)
                begin
                    start_angle_reg <= '0;
                    start_dist_reg  <= '0;
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= in_ch.op;
            dx_reg      <= DX_W'(goal_x_reg) - DX_W'(in_ch.coord_x);
            dy_reg      <= DX_W'(goal_y_reg) - DX_W'(in_ch.coord_y);
            heading_reg <= in_ch.heading;
        end
        if (cmd.sq_init)
        begin
            sum_reg  <= sq_prod;
            cx_reg   <= cx_init;
            cy_reg   <= cy_init;
            acc_reg  <= acc_init;
            zero_reg <= (dx_reg == '0) && (dy_reg == '0);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.sq_add)
        begin
            sum_reg <= sum_reg + sq_prod;
        end
        if (cmd.rot_step)
        begin
            if (32'(cnt_reg) < CORDIC_STEPS)
            begin
                if (cy_reg > 0)
                begin
                    cx_reg  <= cx_reg + ysh;
                    cy_reg  <= cy_reg - xsh;
                    acc_reg <= acc_reg + atan_step(rot_idx);
                end
                else
                begin
                    cx_reg  <= cx_reg - ysh;
                    cy_reg  <= cy_reg + xsh;
                    acc_reg <= acc_reg - atan_step(rot_idx);
                end
            end
            if (32'(cnt_reg) < R_W)
            begin
                sum_reg <= sum_reg << 2;
                if (rem_sh >= root_trial)
                begin
                    rem_reg  <= rem_sh - root_trial;
                    root_reg <= {root_reg[R_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[R_W-2:0], 1'b0};
                end
            end
        end
        if (cmd.ang)
        begin
            rel_reg   <= rel_s;
            arel_reg  <= rel_s[AW-1] ? AW'(-rel_s) : AW'(rel_s);
            ainit_reg <= sa_s[AW-1] ? AW'(-sa_s) : AW'(sa_s);
            dist_reg  <= root_reg;
            drem_reg  <= D_W'(rel_s[AW-1] ? AW'(-rel_s) : AW'(rel_s));
            dden_reg  <= D_W'(sa_s[AW-1] ? AW'(-sa_s) : AW'(sa_s));
        end
        if (cmd.div_step)
        begin
            if (drem_sh >= dden_reg)
            begin
                drem_reg <= drem_sh - dden_reg;
                quo_reg  <= {quo_reg[FRAC_STEPS-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= drem_sh;
                quo_reg  <= {quo_reg[FRAC_STEPS-2:0], 1'b0};
            end
        end
        if (cmd.rp_take)
        begin
            if (ainit_reg == '0)
            begin
                rp_reg <= ONE_Q16;
            end
            else if (arel_reg >= ainit_reg)
            begin
                rp_reg <= '0;
            end
            else
            begin
                rp_reg <= ONE_Q16 - Q16_W'(quo_reg);
            end
            drem_reg <= D_W'(dist_reg);
            dden_reg <= D_W'(start_dist_reg);
        end
        if (cmd.mp_take)
        begin
            if (start_dist_reg == '0)
            begin
                mp_reg <= ONE_Q16;
            end
            else if (dist_reg >= start_dist_reg)
            begin
                mp_reg <= '0;
            end
            else
            begin
                mp_reg <= ONE_Q16 - Q16_W'(quo_reg);
            end
        end
        if (cmd.commit)
        begin
            o_moving_reg  <= move_next;
            o_drive_reg   <= drive_c;
            o_ls_reg      <= SPEED_W'(ls_c);
            o_rs_reg      <= SPEED_W'(rs_c);
            o_lrev_reg    <= lrev_c;
            o_rrev_reg    <= rrev_c;
            o_arrived_reg <= (gx_next == '0) && (gy_next == '0);
        end
    end

    assign in_ch.ready          = cmd.take;
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.moving        = o_moving_reg;
    assign out_ch.drive_on      = o_drive_reg;
    assign out_ch.left_speed    = o_ls_reg;
    assign out_ch.right_speed   = o_rs_reg;
    assign out_ch.left_reverse  = o_lrev_reg;
    assign out_ch.right_reverse = o_rrev_reg;
    assign out_ch.arrived       = o_arrived_reg;

    assign sts.in_valid = in_ch.valid;
    assign sts.in_tick  = in_ch.op == OP_TICK;
    assign sts.rot_last = cnt_reg == CNT_W'(ROT_STEPS - 1);
    assign sts.div_last = cnt_reg == CNT_W'(FRAC_STEPS - 1);
    assign sts.out_free = !out_valid_reg || out_ch.ready;

endmodule

// ----- design/differential_drive_goto_controller_unit.sv -----
// top level of the differential-drive go-to-point controller
//
// in_ch takes one request at a time: a set-target-x, a set-target-y or a
// control tick carrying the pose (x, y, binary heading). out_ch returns one
// result per request: move flag, drive enable, left/right Q8.8 speeds with
// direction bits and the arrived flag.
// a set request goes from acceptance straight to the final state (S_FIN).
// a tick runs squaring (S_SQ0, S_SQ1), a shared cordic/root loop (S_ROT),
// a capture step (S_ANG), two 16-step restoring divisions (S_DIVA, S_DIVD)
// each followed by a step that takes the quotient (S_RPT, S_MPT), and the
// final state, which registers the result.
// in_ch.ready is high only while the sequencer waits for a request, so one
// request is in work at a time.
// a finished result sits in the output register; in_ch accepts the next
// request while it waits, and a stalled out_ch holds the next result in its
// final state until the register frees up.
// reset clears the mode to standby, the target to (0,0) and the start values.
`include "differential_drive_goto_controller_unit_assert.svh"
module differential_drive_goto_controller_unit #(
    parameter int POS_WIDTH   = ddgc_pkg::POS_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ddgc_pkg::ANGLE_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ddgc_in_if.sink    in_ch,
    ddgc_out_if.source out_ch
);
    import ddgc_pkg::*;

    // command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    ddgc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // arithmetic, goal and start registers, result register
    ddgc_datapath #(
        .POS_WIDTH   (POS_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // a request is never taken twice in a row
    `DDGC_ASSERT_NEXT(a_one_in_work, in_ch.valid && in_ch.ready, !in_ch.ready)
    // driving implies the move mode is kept
    `DDGC_ASSERT_IMPLY(a_drive_moving, out_ch.valid && out_ch.drive_on, out_ch.moving)
    // no result reverses both wheels; a spin reverses exactly one
    `DDGC_ASSERT_IMPLY(a_one_reverse, out_ch.valid, !(out_ch.left_reverse && out_ch.right_reverse))

endmodule

// ----- sim/tb_differential_drive_goto_controller_unit.sv -----
// self-checking testbench for the differential-drive go-to-point controller
`timescale 1ns / 100ps

module tb_differential_drive_goto_controller_unit;
    import ddgc_pkg::*;

    localparam int PW         = 24;
    localparam int AW         = 16;
    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        logic [1:0]           op;
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic [AW-1:0]        hdg;
    } req_t;

    typedef struct packed {
        logic                      moving;
        logic                      drive_on;
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [SPEED_W-1:0] right_speed;
        logic                      left_reverse;
        logic                      right_reverse;
        logic                      arrived;
    } drive_cmd_t;

    typedef struct {
        req_t       req;
        logic       typed;
        drive_cmd_t cmd;
    } vec_t;

    logic clk;
    logic rst_n;

    ddgc_in_if  #(.POS_WIDTH(PW), .ANGLE_WIDTH(AW)) in_ch ();
    ddgc_out_if out_ch ();

    differential_drive_goto_controller_unit #(.POS_WIDTH(PW), .ANGLE_WIDTH(AW)) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // own copy of the controller state
    logic                 mdl_move;
    logic signed [PW-1:0] mdl_goal_x;
    logic signed [PW-1:0] mdl_goal_y;
    logic [PW:0]          mdl_start_dist;
    logic [AW-1:0]        mdl_start_ang;

    // arctangent of 2^-i, units of 2^-32 turn
    logic [31:0] turn_tab [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    drive_cmd_t speed_cmd_q [$];
    int         n_fail;
    int         n_req;
    int         n_cmd;
    int         n_stop;
    int         n_spin;
    int         idle_cnt;
    logic       quiet;

    // bearing in 2^-32 turn, vectoring cordic on scaled inputs
    function automatic logic [31:0] bearing_t32(input longint dy, input longint dx);
        longint      cx;
        longint      cy;
        longint      t;
        longint      xs;
        longint      ys;
        logic [31:0] acc;
        acc = '0;
        if (dx == 0 && dy == 0)
            return 32'd0;
        cx = dx <<< (60 - PW);
        cy = dy <<< (60 - PW);
        if (cx < 0)
        begin
            if (cy >= 0)
            begin
                t = cx; cx = cy; cy = -t; acc = 32'h4000_0000;
            end
            else
            begin
                t = cx; cx = -cy; cy = t; acc = 32'hC000_0000;
            end
        end
        for (int i = 0; i < 24; i++)
        begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cy > 0)
            begin
                cx = cx + ys; cy = cy - xs; acc = acc + turn_tab[i];
            end
            else
            begin
                cx = cx - ys; cy = cy + xs; acc = acc - turn_tab[i];
            end
        end
        return acc;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned rem;
        longint unsigned t;
        r = 0;
        rem = 0;
        for (int k = 62; k >= 0; k -= 2)
        begin
            rem = (rem << 2) | ((v >> k) & 64'd3);
            t = (r << 2) | 64'd1;
            if (rem >= t)
            begin
                rem = rem - t;
                r = (r << 1) | 64'd1;
            end
            else
                r = r << 1;
        end
        return r;
    endfunction

    // advance the state by one request and return the wheel command it yields
    function automatic drive_cmd_t predict_drive(input req_t rq);
        drive_cmd_t      c;
        longint          dx, dy, rel, ls, rs, tt;
        longint unsigned bear, arel, ainit, span, rp, mp, adx, ady;
        logic [AW-1:0]   relu;
        longint          quarter;
        quarter = longint'(1) << (AW - 2);
        ls = 0;
        rs = 0;
        c = '0;
        if (rq.op == OP_SET_X)
            mdl_goal_x = rq.x;
        else if (rq.op == OP_SET_Y)
            mdl_goal_y = rq.y;
        else if (rq.op == OP_TICK)
        begin
            dx = longint'(mdl_goal_x) - longint'(rq.x);
            dy = longint'(mdl_goal_y) - longint'(rq.y);
            bear = (64'(bearing_t32(dy, dx)) + (64'd1 << (31 - AW))) >> (32 - AW);
            relu = AW'(bear) - rq.hdg;
            rel = longint'(signed'(relu));
            if (mdl_start_ang == 0)
                mdl_start_ang = relu;
            arel = rel < 0 ? -rel : rel;
            ainit = longint'(signed'(mdl_start_ang)) < 0 ?
                    -longint'(signed'(mdl_start_ang)) : longint'(signed'(mdl_start_ang));
            if (ainit == 0)
                rp = 65536;
            else if (arel >= ainit)
                rp = 0;
            else
                rp = 65536 - (arel * 65536) / ainit;
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            span = root_floor(adx * adx + ady * ady);
            if (mdl_start_dist == 0)
                mdl_start_dist = span;
            if (mdl_start_dist == 0)
                mp = 65536;
            else if (span >= mdl_start_dist)
                mp = 0;
            else
                mp = 65536 - (span * 65536) / mdl_start_dist;
            if (!mdl_move)
            begin
                // standby tick: clear start values, arm when a goal is set
                mdl_start_dist = '0;
                mdl_start_ang = '0;
                if (mdl_goal_x != 0 || mdl_goal_y != 0)
                    mdl_move = 1'b1;
            end
            else
            begin
                c.drive_on = 1'b1;
                if (mp * 5 < 4 * 65536 && rp * 10 > 7 * 65536)
                begin
                    tt = longint'((80 * (65536 - rp)) >> 8);
                    if (rel < 0)
                    begin
                        ls += tt; rs -= tt;
                    end
                    else
                    begin
                        ls -= tt; rs += tt;
                    end
                end
                ls += longint'((120 * mp) >> 8);
                rs += longint'((120 * mp) >> 8);
                // spin in place when far off heading early in the move
                if ((arel << (32 - AW)) > 64'd341782638 && mp * 2 < 65536)
                begin
                    ls = 80 * 256 + longint'((120 * (65536 - rp)) >> 8);
                    rs = ls;
                    n_spin++;
                    if (rel > 0)
                        c.left_reverse = 1'b1;
                    else
                        c.right_reverse = 1'b1;
                end
                // target behind and more than half way: give up the goal
                if ((rel > quarter || rel < -quarter) && mp * 2 > 65536)
                begin
                    mdl_move = 1'b0;
                    mdl_goal_x = '0;
                    mdl_goal_y = '0;
                    c.drive_on = 1'b0;
                    n_stop++;
                end
            end
        end
        c.moving = mdl_move;
        c.left_speed = SPEED_W'(ls);
        c.right_speed = SPEED_W'(rs);
        c.arrived = (mdl_goal_x == 0 && mdl_goal_y == 0);
        return c;
    endfunction

    function automatic vec_t row(input logic [1:0] op, input longint x, input longint y,
                                 input longint h, input logic typed = 1'b0,
                                 input logic arr = 1'b0);
        vec_t v;
        v.req = '{op, PW'(x), PW'(y), AW'(h)};
        v.typed = typed;
        v.cmd = '0;
        v.cmd.arrived = arr;
        return v;
    endfunction

    // drive one request and wait for its acceptance
    task automatic send_req(input req_t rq, input logic typed, input drive_cmd_t cmd);
        drive_cmd_t p;
        int         gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.op      <= rq.op;
        in_ch.coord_x <= rq.x;
        in_ch.coord_y <= rq.y;
        in_ch.heading <= rq.hdg;
        do
            @(posedge clk);
        while (!in_ch.ready);
        p = predict_drive(rq);
        speed_cmd_q.push_back(typed ? cmd : p);
        n_req++;
    endtask

    function automatic longint rnd_coord(input logic wide);
        if (wide)
            return longint'(signed'(PW'($urandom)));
        return longint'($urandom_range(0, 4000)) - 2000;
    endfunction

    // stimulus
    initial
    begin
        vec_t   dir [$];
        req_t   rq;
        longint sx, sy, gx, gy;
        int     nt;
        logic   wide;
        in_ch.valid   <= 1'b0;
        in_ch.op      <= OP_TICK;
        in_ch.coord_x <= '0;
        in_ch.coord_y <= '0;
        in_ch.heading <= '0;
        n_fail = 0; n_req = 0; n_cmd = 0; n_stop = 0; n_spin = 0;
        quiet = 1'b0;
        mdl_move = 1'b0;
        mdl_goal_x = '0;
        mdl_goal_y = '0;
        mdl_start_dist = '0;
        mdl_start_ang = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset state, extremes, unused op, zero start values,
        // standby arm, turning, spin in place, stop, arrival
        dir.push_back(row(OP_TICK, 0, 0, 0, 1'b1, 1'b1));
        dir.push_back(row(2'd3, -1, -1, 65535, 1'b1, 1'b1));
        dir.push_back(row(OP_SET_X, 8388607, 0, 0, 1'b1, 1'b0));
        dir.push_back(row(OP_SET_Y, 0, -8388608, 0, 1'b1, 1'b0));
        dir.push_back(row(OP_TICK, -8388608, 8388607, 65535));
        dir.push_back(row(OP_TICK, -8388608, 8388607, 65535));
        dir.push_back(row(OP_TICK, 0, 0, 32768));
        dir.push_back(row(OP_SET_X, 1000, 0, 0));
        dir.push_back(row(OP_SET_Y, 0, 0, 0));
        dir.push_back(row(OP_TICK, 0, 0, 0));
        dir.push_back(row(OP_TICK, 0, 0, 0));
        dir.push_back(row(OP_TICK, 0, 0, 12000));
        dir.push_back(row(OP_TICK, 500, 0, 0));
        dir.push_back(row(OP_TICK, 900, 0, 16384));
        dir.push_back(row(OP_TICK, 900, 0, 32768));
        dir.push_back(row(OP_SET_Y, 0, 300, 0));
        dir.push_back(row(OP_TICK, 0, 0, 0));
        dir.push_back(row(OP_TICK, 0, 0, 40000));
        dir.push_back(row(OP_TICK, 0, 300, 0));
        dir.push_back(row(OP_TICK, 0, 0, 49152));
        dir.push_back(row(OP_SET_Y, 0, 0, 0));
        dir.push_back(row(OP_SET_X, 0, 0, 0));
        dir.push_back(row(OP_TICK, 5, 5, 100));
        foreach (dir[i])
            send_req(dir[i].req, dir[i].typed, dir[i].cmd);

        // random: goal then a walk of ticks toward it, with noise between
        while (n_req < 820)
        begin
            if (n_req > 700)
                quiet = 1'b1;
            if ($urandom_range(0, 4) == 0)
            begin
                rq = '{2'($urandom), PW'($urandom), PW'($urandom), AW'($urandom)};
                send_req(rq, 1'b0, '0);
            end
            else
            begin
                wide = ($urandom_range(0, 5) == 0);
                gx = rnd_coord(wide);
                gy = rnd_coord(wide);
                sx = rnd_coord(wide);
                sy = rnd_coord(wide);
                send_req('{OP_SET_X, PW'(gx), PW'($urandom), AW'($urandom)}, 1'b0, '0);
                send_req('{OP_SET_Y, PW'($urandom), PW'(gy), AW'($urandom)}, 1'b0, '0);
                nt = $urandom_range(3, 12);
                for (int k = 0; k <= nt; k++)
                begin
                    rq.op  = OP_TICK;
                    rq.x   = PW'(sx + (gx - sx) * k / nt);
                    rq.y   = PW'(sy + (gy - sy) * k / nt);
                    rq.hdg = $urandom_range(0, 1) ? AW'($urandom) :
                             AW'($urandom_range(0, 3000) - 1500);
                    send_req(rq, 1'b0, '0);
                end
            end
        end
        in_ch.valid <= 1'b0;
        while (speed_cmd_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("covered %0d requests and %0d wheel commands, %0d spins, %0d stops",
                 n_req, n_cmd, n_spin, n_stop);
        if (n_fail == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // result side: random stall bursts, compare with oldest expectation
    int stall_left;

    always @(posedge clk or negedge rst_n)
    begin
        drive_cmd_t e;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                n_cmd++;
                if (speed_cmd_q.size() == 0)
                begin
                    $error("wheel command with no request waiting");
                    n_fail++;
                end
                else
                begin
                    e = speed_cmd_q.pop_front();
                    if (out_ch.moving !== e.moving)
                    begin
                        $error("moving exp %0d got %0d", e.moving, out_ch.moving);
                        n_fail++;
                    end
                    if (out_ch.drive_on !== e.drive_on)
                    begin
                        $error("drive_on exp %0d got %0d", e.drive_on, out_ch.drive_on);
                        n_fail++;
                    end
                    if (out_ch.left_speed !== e.left_speed)
                    begin
                        $error("left_speed exp %0d got %0d", e.left_speed, out_ch.left_speed);
                        n_fail++;
                    end
                    if (out_ch.right_speed !== e.right_speed)
                    begin
                        $error("right_speed exp %0d got %0d", e.right_speed,
                               out_ch.right_speed);
                        n_fail++;
                    end
                    if (out_ch.left_reverse !== e.left_reverse)
                    begin
                        $error("left_reverse exp %0d got %0d", e.left_reverse,
                               out_ch.left_reverse);
                        n_fail++;
                    end
                    if (out_ch.right_reverse !== e.right_reverse)
                    begin
                        $error("right_reverse exp %0d got %0d", e.right_reverse,
                               out_ch.right_reverse);
                        n_fail++;
                    end
                    if (out_ch.arrived !== e.arrived)
                    begin
                        $error("arrived exp %0d got %0d", e.arrived, out_ch.arrived);
                        n_fail++;
                    end
                end
            end
            // random stall bursts, none near the end
            if (stall_left > 0)
                stall_left--;
            else if (!quiet && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 9);
            out_ch.ready <= (stall_left == 0);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
